@@ hdl/uulbe_pkg.sv @@
// Shared types, constants and microcode program for the uuencode line/block encoder.
`default_nettype none

package uulbe_pkg;

    // Fixed field widths
    localparam int DATA_W   = 8;
    localparam int LEFT_W   = 14;
    localparam int LBC_W    = 6;
    localparam int LC_W     = 5;
    localparam int SUM_W    = 18;
    localparam int HELD_W   = 16;
    localparam int GRP_W    = 24;
    localparam int STEP_W   = 4;
    localparam int NDIG     = 6;
    localparam int NDIG_W   = 3;
    localparam int DIG_W    = 4;

    // Defaults for the top-level parameters
    localparam int BYTES_PER_LINE_DEF     = 45;
    localparam int LINES_PER_CHECKSUM_DEF = 20;

    // Character codes
    localparam logic [7:0] CHR_CR    = 8'h0D;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_BTICK = 8'h60;
    localparam logic [7:0] CHR_ZERO  = 8'h30;

    // Divide-by-ten reciprocal: q = (v * RECIP10) >> RECIP_SH, exact for v < 2^18
    localparam int RECIP_SH = 22;
    localparam int RECIP_W  = 19;
    localparam logic [RECIP_W-1:0] RECIP10 = 19'd419431;
    localparam int PROD_W   = SUM_W + RECIP_W;

    typedef enum logic [3:0] {
        OP_LEN,
        OP_G0,
        OP_G1,
        OP_G2,
        OP_G3,
        OP_CR,
        OP_DIV,
        OP_DIG,
        OP_CSCR,
        OP_END
    } t_op;

    typedef enum logic [2:0] {
        C_ALWAYS,
        C_NEED_LEN,
        C_GRP,
        C_LINE,
        C_CS,
        C_DIV_MORE,
        C_DIG_MORE,
        C_NEVER
    } t_cond;

    typedef struct packed {
        t_op               op;
        t_cond             guard;
        logic [STEP_W-1:0] skip_to;
        t_cond             rpt;
    } t_uword;

    typedef struct packed {
        logic need_len;
        logic grp;
        logic line;
        logic cs;
        logic div_more;
        logic dig_more;
    } t_conds;

    typedef struct packed {
        t_op  op;
        logic fire;
    } t_seq_ctl;

    localparam logic [STEP_W-1:0] STEP_G0  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_END = 4'd9;

    // Microcode program: guard false jumps to skip_to, rpt true holds the step
    function automatic t_uword ucode(input logic [STEP_W-1:0] step);
        t_uword w;
        w = '{op: OP_END, guard: C_ALWAYS, skip_to: STEP_END, rpt: C_NEVER};
        unique case (step)
            4'd0:    w = '{op: OP_LEN,  guard: C_NEED_LEN, skip_to: STEP_G0,  rpt: C_NEVER};
            4'd1:    w = '{op: OP_G0,   guard: C_GRP,      skip_to: STEP_END, rpt: C_NEVER};
            4'd2:    w = '{op: OP_G1,   guard: C_ALWAYS,   skip_to: STEP_END, rpt: C_NEVER};
            4'd3:    w = '{op: OP_G2,   guard: C_ALWAYS,   skip_to: STEP_END, rpt: C_NEVER};
            4'd4:    w = '{op: OP_G3,   guard: C_ALWAYS,   skip_to: STEP_END, rpt: C_NEVER};
            4'd5:    w = '{op: OP_CR,   guard: C_LINE,     skip_to: STEP_END, rpt: C_NEVER};
            4'd6:    w = '{op: OP_DIV,  guard: C_CS,       skip_to: STEP_END, rpt: C_DIV_MORE};
            4'd7:    w = '{op: OP_DIG,  guard: C_ALWAYS,   skip_to: STEP_END, rpt: C_DIG_MORE};
            4'd8:    w = '{op: OP_CSCR, guard: C_ALWAYS,   skip_to: STEP_END, rpt: C_NEVER};
            default: w = '{op: OP_END,  guard: C_ALWAYS,   skip_to: STEP_END, rpt: C_NEVER};
        endcase
        return w;
    endfunction

    function automatic logic cond_eval(input t_cond c, input t_conds f);
        logic r;
        r = 1'b0;
        unique case (c)
            C_ALWAYS:   r = 1'b1;
            C_NEED_LEN: r = f.need_len;
            C_GRP:      r = f.grp;
            C_LINE:     r = f.line;
            C_CS:       r = f.cs;
            C_DIV_MORE: r = f.div_more;
            C_DIG_MORE: r = f.dig_more;
            C_NEVER:    r = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_emit(input t_op op);
        return (op != OP_DIV) && (op != OP_END);
    endfunction

    // Printable 6-bit value, space sent as backtick
    function automatic logic [7:0] uu_char(input logic [5:0] v);
        return (v == 6'd0) ? CHR_BTICK : (CHR_SPACE + {2'b00, v});
    endfunction

endpackage

`default_nettype wire

@@ hdl/uulbe_seq.sv @@
// Microcode sequencer: step counter, program lookup and jump control.
`default_nettype none

module uulbe_seq
    import uulbe_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_start,
    input  wire logic     i_out_free,
    input  wire t_conds   i_conds,
    output t_seq_ctl      o_ctl,
    output logic          o_busy
);

    logic [STEP_W-1:0] r_step, n_step;
    logic              r_busy, n_busy;
    t_uword            w;
    logic              guard_ok;
    logic              go;

    assign w        = ucode(r_step);
    assign guard_ok = cond_eval(w.guard, i_conds);
    // An emitting step waits for room in the output register
    assign go       = r_busy && guard_ok && (!is_emit(w.op) || i_out_free);

    always_comb begin
        o_ctl.op   = w.op;
        o_ctl.fire = go;
        o_busy     = r_busy;
    end

    always_comb begin
        n_step = r_step;
        n_busy = r_busy;
        if (r_busy) begin
            if (!guard_ok) begin
                n_step = w.skip_to;
            end else if (go) begin
                if (w.op == OP_END) begin
                    n_busy = 1'b0;
                    n_step = '0;
                end else if (!cond_eval(w.rpt, i_conds)) begin
                    n_step = r_step + 1'b1;
                end
            end
        end else if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
            r_busy <= 1'b0;
        end else begin
            r_step <= n_step;
            r_busy <= n_busy;
        end
    end

endmodule

`default_nettype wire

@@ hdl/uu_line_block_encoder_core.sv @@
// Top level of the uuencode line encoder with per-block decimal checksum.
`default_nettype none

//  channel  direction  handshake           payload
//  in       input      i_valid / o_ready   i_data_byte, i_bytes_left
//  out      output     o_valid / i_ready   o_out_char, o_line_end, o_checksum_line, o_last
//
//  Each byte is taken in one transaction, then runs one microcode step per cycle
//  while no emitting step waits for output room (one per emitted character, one per
//  skipped step, up to six divide-by-ten steps for the checksum digits and one closing step).
//  A byte that opens a line, closes it and brings a six-digit checksum sets the
//  worst case: thirteen characters, six divide steps and the closing step.
//  Reset (synchronous, active low) clears the line/group/sum state and the sequencer.
//  A stalled output holds its character; the sequencer waits until it is taken.

module uu_line_block_encoder_core
    import uulbe_pkg::*;
#(
    parameter int BYTES_PER_LINE     = BYTES_PER_LINE_DEF,
    parameter int LINES_PER_CHECKSUM = LINES_PER_CHECKSUM_DEF
)(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [DATA_W-1:0] i_data_byte,
    input  wire logic [LEFT_W-1:0] i_bytes_left,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic [7:0]             o_out_char,
    output logic                   o_line_end,
    output logic                   o_checksum_line,
    output logic                   o_last
);

    localparam logic [LBC_W-1:0]  BPL   = LBC_W'(BYTES_PER_LINE);
    localparam logic [LEFT_W-1:0] BPL_L = LEFT_W'(BYTES_PER_LINE);
    localparam logic [LC_W-1:0]   LPC   = LC_W'(LINES_PER_CHECKSUM);

    // ---------------------------------------------------------------
    // Encoder state carried from byte to byte
    // ---------------------------------------------------------------
    logic [HELD_W-1:0] r_held;
    logic [1:0]        r_fill;
    logic [LBC_W-1:0]  r_lbc;
    logic [LC_W-1:0]   r_lc;
    logic [SUM_W-1:0]  r_sum;

    // Per-transaction job registers read by the microcode steps
    logic [GRP_W-1:0]  r_grp;
    logic [7:0]        r_len_char;
    logic              r_need_len, r_do_grp, r_do_line, r_do_cs;
    logic [SUM_W-1:0]  r_div_val;
    logic [NDIG_W-1:0] r_nd;
    logic [DIG_W-1:0]  r_dig [NDIG];

    // Output register
    logic              r_out_valid;
    logic [7:0]        r_out_char;
    logic              r_out_le, r_out_cs, r_out_last;

    logic              accept;
    logic              out_free;
    logic              busy;
    t_seq_ctl          ctl;
    t_conds            conds;

    // Accept-time arithmetic
    logic              is_last;
    logic [LBC_W-1:0]  lbc_new;
    logic [1:0]        fill_new;
    logic              line_done;
    logic              grp_out;
    logic [GRP_W-1:0]  full;
    logic [GRP_W-1:0]  padded;
    logic [SUM_W-1:0]  sum_new;
    logic [LC_W-1:0]   lc_new;
    logic              cs_out;
    logic [LEFT_W-1:0] len_val;

    // Divide-by-ten datapath
    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  quo;
    logic [SUM_W-1:0]  quo10;
    logic [SUM_W-1:0]  rem_full;

    // Emit datapath
    logic              load;
    logic [7:0]        n_out_char;
    logic              n_out_le, n_out_cs, n_out_last;

    assign o_ready  = !busy;
    assign accept   = i_valid && o_ready;
    assign out_free = !r_out_valid || i_ready;

    assign o_valid         = r_out_valid;
    assign o_out_char      = r_out_char;
    assign o_line_end      = r_out_le;
    assign o_checksum_line = r_out_cs;
    assign o_last          = r_out_last;

    // ---------------------------------------------------------------
    // Byte intake: group packing, line and checksum bookkeeping
    // ---------------------------------------------------------------
    always_comb begin
        is_last   = (i_bytes_left <= LEFT_W'(1));
        lbc_new   = r_lbc + 1'b1;
        fill_new  = r_fill + 1'b1;
        line_done = is_last || (lbc_new >= BPL);
        grp_out   = (fill_new == 2'd3) || line_done;
        full      = {r_held, i_data_byte};
        // Pad a short group with zero bytes at the low end
        unique case (fill_new)
            2'd1:    padded = {full[7:0], 16'd0};
            2'd2:    padded = {full[15:0], 8'd0};
            default: padded = full;
        endcase
        sum_new   = r_sum + SUM_W'(i_data_byte);
        lc_new    = r_lc + 1'b1;
        cs_out    = line_done && ((lc_new >= LPC) || is_last);
        len_val   = (i_bytes_left < BPL_L) ? i_bytes_left : BPL_L;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
            r_fill <= '0;
            r_lbc  <= '0;
            r_lc   <= '0;
            r_sum  <= '0;
        end else if (accept) begin
            r_lbc  <= line_done ? '0 : lbc_new;
            r_held <= grp_out ? '0 : full[HELD_W-1:0];
            r_fill <= grp_out ? '0 : fill_new;
            if (line_done) begin
                r_lc <= cs_out ? '0 : lc_new;
            end
            r_sum  <= cs_out ? '0 : sum_new;
        end
    end

    // Latch the job for the sequencer
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_grp      <= padded;
            r_len_char <= uu_char(len_val[5:0]);
            r_need_len <= (r_lbc == '0);
            r_do_grp   <= grp_out;
            r_do_line  <= line_done;
            r_do_cs    <= cs_out;
        end
    end

    // ---------------------------------------------------------------
    // Checksum conversion: one digit per step, pushed on a digit stack
    // ---------------------------------------------------------------
    always_comb begin
        prod     = PROD_W'(r_div_val) * PROD_W'(RECIP10);
        quo      = SUM_W'(prod[PROD_W-1:RECIP_SH]);
        quo10    = (quo << 3) + (quo << 1);
        rem_full = r_div_val - quo10;
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_div_val <= sum_new;
            r_nd      <= '0;
        end else if (ctl.fire && ctl.op == OP_DIV) begin
            // Push the new low digit; earlier digits move up
            r_div_val <= quo;
            r_nd      <= r_nd + 1'b1;
            r_dig[0]  <= rem_full[DIG_W-1:0];
            for (int i = 1; i < NDIG; i++) begin
                r_dig[i] <= r_dig[i-1];
            end
        end else if (ctl.fire && ctl.op == OP_DIG) begin
            // Pop the most significant digit
            r_nd <= r_nd - 1'b1;
            for (int i = 0; i < NDIG - 1; i++) begin
                r_dig[i] <= r_dig[i+1];
            end
        end
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb begin
        conds.need_len = r_need_len;
        conds.grp      = r_do_grp;
        conds.line     = r_do_line;
        conds.cs       = r_do_cs;
        conds.div_more = (quo != '0) && (r_nd < NDIG_W'(NDIG - 1));
        conds.dig_more = (r_nd > NDIG_W'(1));
    end

    uulbe_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_out_free (out_free),
        .i_conds    (conds),
        .o_ctl      (ctl),
        .o_busy     (busy)
    );

    // ---------------------------------------------------------------
    // Character select for the emitting steps
    // ---------------------------------------------------------------
    assign load = ctl.fire && is_emit(ctl.op);

    always_comb begin
        n_out_char = CHR_CR;
        n_out_le   = 1'b0;
        n_out_cs   = 1'b0;
        n_out_last = 1'b0;
        unique case (ctl.op)
            OP_LEN: begin
                n_out_char = r_len_char;
                n_out_last = !r_do_grp;
            end
            OP_G0: n_out_char = uu_char(r_grp[23:18]);
            OP_G1: n_out_char = uu_char(r_grp[17:12]);
            OP_G2: n_out_char = uu_char(r_grp[11:6]);
            OP_G3: begin
                n_out_char = uu_char(r_grp[5:0]);
                n_out_last = !r_do_line;
            end
            OP_CR: begin
                n_out_char = CHR_CR;
                n_out_le   = 1'b1;
                n_out_last = !r_do_cs;
            end
            OP_DIG: begin
                n_out_char = CHR_ZERO + {4'd0, r_dig[0]};
                n_out_cs   = 1'b1;
            end
            OP_CSCR: begin
                n_out_char = CHR_CR;
                n_out_le   = 1'b1;
                n_out_cs   = 1'b1;
                n_out_last = 1'b1;
            end
            default: begin
                n_out_char = CHR_CR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_char <= n_out_char;
            r_out_le   <= n_out_le;
            r_out_cs   <= n_out_cs;
            r_out_last <= n_out_last;
        end
    end

endmodule

`default_nettype wire

@@ tb/sv/uu_line_block_encoder_core_tb.sv @@
// Self-checking testbench for the uuencode line encoder with per-block decimal checksum.
`timescale 1ns / 100ps

module uu_line_block_encoder_core_tb
    import uulbe_pkg::*;
;

    localparam int LINE_BYTES   = BYTES_PER_LINE_DEF;
    localparam int CSUM_LINES   = LINES_PER_CHECKSUM_DEF;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_AT      = 30;   // transactions taken before the long output stall
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 40;   // margin for a worst-case byte to finish

    // One input transaction
    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [LEFT_W-1:0] left;
    } t_src_item;

    // One encoded character as it should leave the block
    typedef struct packed {
        logic [7:0] ch;
        logic       eol;
        logic       csum;
        logic       fin;
    } t_enc_char;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [DATA_W-1:0] i_data_byte = '0;
    logic [LEFT_W-1:0] i_bytes_left = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [7:0]        o_out_char;
    logic              o_line_end;
    logic              o_checksum_line;
    logic              o_last;

    t_src_item pending_bytes[$];
    t_enc_char expected_chars[$];
    t_src_item offer;
    t_enc_char want;

    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int bytes_taken = 0;
    int stall_left = 0;
    bit stall_armed = 1'b1;
    int fail_count = 0;
    int cycle_count = 0;

    // Encoder state mirrored by the predictor
    logic [HELD_W-1:0] held_pair = '0;
    logic [1:0]        held_count = '0;
    logic [LBC_W-1:0]  line_bytes = '0;
    logic [LC_W-1:0]   lines_since_sum = '0;
    logic [SUM_W-1:0]  byte_sum = '0;

    uu_line_block_encoder_core #(
        .BYTES_PER_LINE     (LINE_BYTES),
        .LINES_PER_CHECKSUM (CSUM_LINES)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_byte     (i_data_byte),
        .i_bytes_left    (i_bytes_left),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_char      (o_out_char),
        .o_line_end      (o_line_end),
        .o_checksum_line (o_checksum_line),
        .o_last          (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Map a 6-bit value to its printable character; a space goes out as a backtick
    function automatic logic [7:0] sixbit_char(input logic [5:0] v);
        logic [7:0] c;
        c = CHR_SPACE + {2'b00, v};
        return (c == CHR_SPACE) ? CHR_BTICK : c;
    endfunction

    function automatic t_enc_char char_of(input logic [7:0] c, input logic eol,
                                          input logic csum);
        t_enc_char r;
        r.ch   = c;
        r.eol  = eol;
        r.csum = csum;
        r.fin  = 1'b0;
        return r;
    endfunction

    // Advance the mirrored state by one byte and queue the characters it releases
    task automatic encode_byte(input logic [DATA_W-1:0] d, input logic [LEFT_W-1:0] left);
        t_enc_char  outc[13];
        int         n;
        int         fill;
        logic       is_last;
        logic       line_done;
        logic [GRP_W-1:0] grp;
        logic [SUM_W-1:0] s;
        logic [3:0] digs[6];
        int         nd;
        n = 0;
        is_last = (left <= 1);

        // length character opens a fresh line
        if (line_bytes == 0) begin
            outc[n] = char_of(sixbit_char((left < LINE_BYTES) ? left[5:0] : 6'(LINE_BYTES)),
                              1'b0, 1'b0);
            n++;
        end

        grp = {held_pair, d};
        fill = held_count + 1;
        line_bytes = line_bytes + 1'b1;
        byte_sum = byte_sum + d;
        line_done = is_last || (line_bytes >= LINE_BYTES);

        // flush a full group, or pad the partial one at the end of the line
        if (fill == 3 || line_done) begin
            grp = grp << (8 * (3 - fill));
            outc[n]     = char_of(sixbit_char(grp[23:18]), 1'b0, 1'b0);
            outc[n + 1] = char_of(sixbit_char(grp[17:12]), 1'b0, 1'b0);
            outc[n + 2] = char_of(sixbit_char(grp[11:6]), 1'b0, 1'b0);
            outc[n + 3] = char_of(sixbit_char(grp[5:0]), 1'b0, 1'b0);
            n += 4;
            held_pair = '0;
            held_count = '0;
        end else begin
            held_pair = grp[HELD_W-1:0];
            held_count = fill[1:0];
        end

        if (line_done) begin
            outc[n] = char_of(CHR_CR, 1'b1, 1'b0);
            n++;
            line_bytes = '0;
            lines_since_sum = lines_since_sum + 1'b1;
            if (lines_since_sum >= CSUM_LINES || is_last) begin
                // decimal sum, most significant digit first, no leading zeros
                s = byte_sum;
                nd = 0;
                do begin
                    digs[nd] = 4'(s % 10);
                    s = SUM_W'(s / 10);
                    nd++;
                end while (s != 0 && nd < NDIG);
                while (nd > 0) begin
                    nd--;
                    outc[n] = char_of(CHR_ZERO + {4'h0, digs[nd]}, 1'b0, 1'b1);
                    n++;
                end
                outc[n] = char_of(CHR_CR, 1'b1, 1'b1);
                n++;
                lines_since_sum = '0;
                byte_sum = '0;
            end
        end

        if (n > 0) outc[n - 1].fin = 1'b1;
        for (int k = 0; k < n; k++) expected_chars.push_back(outc[k]);
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] got_v);
        if (got_v !== exp_v) begin
            fail_count++;
            $display("%0t: %s mismatch, expected 0x%02h, actual 0x%02h",
                     $time, name, exp_v, got_v);
        end
    endtask

    task automatic queue_item(input logic [DATA_W-1:0] d, input logic [LEFT_W-1:0] left);
        t_src_item it;
        it.data = d;
        it.left = left;
        pending_bytes.push_back(it);
    endtask

    // Queue one block with an honest countdown; noisy blocks get stray counts and
    // sometimes end on a zero count
    task automatic queue_block(input int len, input int lo, input int hi, input bit noisy);
        t_src_item it;
        for (int k = len; k >= 1; k--) begin
            it.data = DATA_W'($urandom_range(hi, lo));
            if (k == 1)
                it.left = (noisy && $urandom_range(9) == 0) ? LEFT_W'(0) : LEFT_W'(1);
            else if (noisy && $urandom_range(19) == 0)
                it.left = LEFT_W'($urandom);
            else
                it.left = LEFT_W'(k);
            pending_bytes.push_back(it);
        end
    endtask

    // Mostly short blocks, some spanning several lines; the last block is cut to
    // hit the requested byte count exactly
    task automatic queue_random_blocks(input int count);
        int remaining;
        int len;
        int r;
        remaining = count;
        while (remaining > 0) begin
            r = $urandom_range(9);
            if (r < 6)      len = $urandom_range(20, 1);
            else if (r < 9) len = $urandom_range(100, 21);
            else            len = $urandom_range(140, 101);
            if (len > remaining) len = remaining;
            queue_block(len, 0, 255, 1'b1);
            remaining -= len;
        end
    endtask

    // Hold until every queued byte is taken and every character has come out
    task automatic wait_drained();
        while (pending_bytes.size() != 0 || i_valid || expected_chars.size() != 0)
            @(negedge i_clk);
    endtask

    // Input driver: offer the next pending byte, predict on each accepted transaction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                encode_byte(i_data_byte, i_bytes_left);
                bytes_taken <= bytes_taken + 1;
            end
            if (!i_valid || o_ready) begin
                if (pending_bytes.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                    offer = pending_bytes.pop_front();
                    i_valid <= 1'b1;
                    i_data_byte <= offer.data;
                    i_bytes_left <= offer.left;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Long output stall once, so the block backs up and drops o_ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            stall_left <= 0;
            stall_armed <= 1'b1;
        end else if (stall_armed && bytes_taken >= HOLD_AT) begin
            stall_left <= HOLD_CYCLES;
            stall_armed <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= (stall_left == 0) && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Output monitor: compare each accepted character with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_chars.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected character, expected none, actual 0x%02h",
                         $time, o_out_char);
            end else begin
                want = expected_chars.pop_front();
                check_field("out_char", want.ch, o_out_char);
                check_field("line_end", {7'h0, want.eol}, {7'h0, o_line_end});
                check_field("checksum_line", {7'h0, want.csum}, {7'h0, o_checksum_line});
                check_field("last", {7'h0, want.fin}, {7'h0, o_last});
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed bytes, no idling on either side
        queue_item(8'h00, 14'd0);       // zero count: last byte, length char is a backtick
        queue_item(8'hFF, 14'd1);
        queue_item(8'hAB, 14'd2);       // short group padded with zeros
        queue_item(8'h12, 14'd1);
        queue_item(8'h55, 14'd16383);   // length char saturates
        queue_item(8'hAA, 14'd8192);
        queue_item(8'h3C, 14'd46);
        queue_item(8'hC3, 14'd45);
        queue_item(8'h00, 14'd1);
        queue_item(8'h00, 14'd3);       // all-zero bytes, block ends on a zero count
        queue_item(8'h00, 14'd2);
        queue_item(8'h00, 14'd0);
        queue_item(8'h80, 14'd4);       // one byte left over after a full group
        queue_item(8'h7F, 14'd3);
        queue_item(8'h01, 14'd2);
        queue_item(8'hFE, 14'd1);
        queue_item(8'hFF, 14'd10000);   // three-digit sum
        queue_item(8'hFF, 14'd5000);
        queue_item(8'hFF, 14'd1);
        queue_random_blocks(45);
        wait_drained();

        // Sender idles
        tx_idle_pct = 74;
        rx_stall_pct = 0;
        queue_random_blocks(45);
        wait_drained();

        // Receiver stalls
        tx_idle_pct = 0;
        rx_stall_pct = 74;
        queue_random_blocks(45);
        wait_drained();

        // Both sides idle lightly; one block of heavy bytes fills a whole line and
        // then ends on a fresh line with a five-digit sum
        tx_idle_pct = 8;
        rx_stall_pct = 8;
        queue_random_blocks(30);
        queue_block(LINE_BYTES + 1, 230, 255, 1'b0);
        wait_drained();

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && expected_chars.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
